>>> src/e2q_pkg.sv
package e2q_pkg;

  // working format: 30 fraction bits, 34 bits hold +/- 2*pi with margin
  localparam int WorkBits = 34;
  localparam int WorkFrac = 30;
  localparam int TabLen = 30;

  typedef logic signed [WorkBits-1:0] work_t;

  localparam work_t KPi = 34'sd3373259426;
  localparam work_t KHalfPi = 34'sd1686629713;
  localparam work_t KTwoPi = 34'sd6746518852;
  localparam work_t KGain = 34'sd652032874;

  // arctangent of 2^-i, 30 fraction bits
  function automatic work_t atan_val(input logic [4:0] i);
    work_t r;
    r = '0;
    unique case (i)
      5'd0: r = 34'sd843314856;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043836;
      5'd3: r = 34'sd133525158;
      5'd4: r = 34'sd67021686;
      5'd5: r = 34'sd33543515;
      5'd6: r = 34'sd16775850;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194282;
      5'd9: r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      5'd24: r = 34'sd63;
      5'd25: r = 34'sd31;
      5'd26: r = 34'sd15;
      5'd27: r = 34'sd7;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // one rotator lane
  typedef struct packed {
    work_t x;
    work_t y;
    work_t z;
    logic  neg;
  } lane_t;

  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
  } cell_data_t;

endpackage

>>> src/euler_to_quaternion.sv
// Euler angles (ZYX) to unit quaternion.
// Input stream s_axis: one transfer carries roll, pitch and yaw in signed
// fixed point with ANGLE_BITS-4 fraction bits. Output stream m_axis: one
// transfer per input carrying w, x, y, z in signed fixed point with
// COMPONENT_BITS-2 fraction bits, clamped to +/- 1.0.
// Each angle is halved, folded into [-pi/2, pi/2] and rotated through a
// chain of CORDIC_STEPS cells (capped at e2q_pkg::TabLen), one step per cell; a four-stage product
// section follows.
// Throughput: one item per cycle while the output is not stalled; the
// pipeline is a single chain of registers whose stages all advance together.
// Stalls: when m_axis_tready is low with a valid result waiting, the whole
// chain holds and s_axis_tready drops; no data is lost. s_axis_tready is
// high whenever the output register is empty or being taken.
// Reset clears all stage valid bits; data registers are not reset.
module euler_to_quaternion #(
  parameter int ANGLE_BITS     = 16,
  parameter int COMPONENT_BITS = 16,
  parameter int CORDIC_STEPS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // roll_angle, pitch_angle, yaw_angle from bit 0 up
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z from bit 0 up
  output logic [((4*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata
);

  localparam int Steps = (CORDIC_STEPS < e2q_pkg::TabLen) ? CORDIC_STEPS : e2q_pkg::TabLen;
  localparam int Depth = Steps + 5;
  localparam int OutBits = ((4*COMPONENT_BITS+7)/8)*8;

  logic adv;
  logic [Depth-1:0] vld;
  e2q_pkg::cell_data_t chain [Steps+1];
  logic signed [COMPONENT_BITS-1:0] qw, qx, qy, qz;

  // whole chain moves when the last stage is empty or taken
  assign adv = !vld[Depth-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], s_axis_tvalid};
    end
  end

  e2q_fold #(.ANGLE_BITS(ANGLE_BITS)) u_fold (
    .clk         (clk),
    .en          (adv),
    .roll_angle  (s_axis_tdata[ANGLE_BITS-1:0]),
    .pitch_angle (s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
    .yaw_angle   (s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
    .dout        (chain[0])
  );

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    e2q_cell #(.STEP(g)) u_cell (
      .clk  (clk),
      .en   (adv),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  e2q_combine #(.COMPONENT_BITS(COMPONENT_BITS)) u_comb (
    .clk    (clk),
    .en     ({4{adv}}),
    .din    (chain[Steps]),
    .quat_w (qw),
    .quat_x (qx),
    .quat_y (qy),
    .quat_z (qz)
  );

  assign m_axis_tdata = OutBits'({qz, qy, qx, qw});

  // a held result stays while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input is refused only when a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

  // w never exceeds plus one
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(qw) <= $signed(COMPONENT_BITS'(1) <<< (COMPONENT_BITS-2))))
    else $error("w out of range");

endmodule

>>> src/e2q_cell.sv
// one cordic step for the three angle lanes, registered
module e2q_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  e2q_pkg::cell_data_t din,
  output e2q_pkg::cell_data_t dout
);

  localparam e2q_pkg::work_t Atan = e2q_pkg::atan_val(5'(STEP));

  function automatic e2q_pkg::lane_t rot(input e2q_pkg::lane_t a);
    e2q_pkg::lane_t r;
    r = a;
    if (a.z >= 0) begin
      r.x = a.x - (a.y >>> STEP);
      r.y = a.y + (a.x >>> STEP);
      r.z = a.z - Atan;
    end else begin
      r.x = a.x + (a.y >>> STEP);
      r.y = a.y - (a.x >>> STEP);
      r.z = a.z + Atan;
    end
    return r;
  endfunction

  // stage register, advances when the chain moves
  always_ff @(posedge clk) begin
    if (en) begin
      dout.roll  <= rot(din.roll);
      dout.pitch <= rot(din.pitch);
      dout.yaw   <= rot(din.yaw);
    end
  end

endmodule

>>> src/e2q_fold.sv
// angle widening, halving and quadrant folding, registered
module e2q_fold #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] roll_angle,
  input  logic signed [ANGLE_BITS-1:0] pitch_angle,
  input  logic signed [ANGLE_BITS-1:0] yaw_angle,
  output e2q_pkg::cell_data_t          dout
);

  localparam int Shift = e2q_pkg::WorkFrac - 1 - (ANGLE_BITS - 4);

  function automatic e2q_pkg::lane_t fold(input logic signed [ANGLE_BITS-1:0] a);
    e2q_pkg::lane_t r;
    logic signed [63:0] w;
    e2q_pkg::work_t z;
    w = 64'(a);
    if (Shift >= 0) w = w <<< Shift;
    else w = w >>> (-Shift);
    z = e2q_pkg::WorkBits'(w);
    if (z > e2q_pkg::KPi) z = z - e2q_pkg::KTwoPi;
    else if (z < -e2q_pkg::KPi) z = z + e2q_pkg::KTwoPi;
    r.neg = 1'b0;
    if (z > e2q_pkg::KHalfPi) begin
      z = z - e2q_pkg::KPi;
      r.neg = 1'b1;
    end else if (z < -e2q_pkg::KHalfPi) begin
      z = z + e2q_pkg::KPi;
      r.neg = 1'b1;
    end
    r.x = e2q_pkg::KGain;
    r.y = '0;
    r.z = z;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      dout.roll  <= fold(roll_angle);
      dout.pitch <= fold(pitch_angle);
      dout.yaw   <= fold(yaw_angle);
    end
  end

endmodule

>>> src/e2q_combine.sv
// products, sums, rounding and clamp over four registered stages
module e2q_combine #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk,
  input  logic [3:0]                       en,
  input  e2q_pkg::cell_data_t              din,
  output logic signed [COMPONENT_BITS-1:0] quat_w,
  output logic signed [COMPONENT_BITS-1:0] quat_x,
  output logic signed [COMPONENT_BITS-1:0] quat_y,
  output logic signed [COMPONENT_BITS-1:0] quat_z
);

  localparam int Sh = e2q_pkg::WorkFrac - (COMPONENT_BITS - 2);

  function automatic e2q_pkg::work_t mul(input e2q_pkg::work_t a, input e2q_pkg::work_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + (68'sd1 <<< 29);
    return e2q_pkg::WorkBits'(p >>> 30);
  endfunction

  function automatic logic signed [COMPONENT_BITS-1:0] to_comp(input e2q_pkg::work_t v);
    logic signed [e2q_pkg::WorkBits:0] t;
    logic signed [e2q_pkg::WorkBits:0] lim;
    t = (e2q_pkg::WorkBits+1)'(v);
    lim = (e2q_pkg::WorkBits+1)'(1) <<< (COMPONENT_BITS - 2);
    if (Sh > 0) t = (t + ((e2q_pkg::WorkBits+1)'(1) <<< (Sh - 1))) >>> Sh;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return COMPONENT_BITS'(t);
  endfunction

  e2q_pkg::work_t cr, sr, cp, sp, cy, sy;
  e2q_pkg::work_t cc, sc, cs, ss, cy1, sy1;
  e2q_pkg::work_t ccc, ssc, scc, csc, ccs, sss, scs, css;
  e2q_pkg::work_t sw, sx, sy2, sz;

  // signs of folded angles
  always_comb begin
    cr = din.roll.neg  ? -din.roll.x  : din.roll.x;
    sr = din.roll.neg  ? -din.roll.y  : din.roll.y;
    cp = din.pitch.neg ? -din.pitch.x : din.pitch.x;
    sp = din.pitch.neg ? -din.pitch.y : din.pitch.y;
    cy = din.yaw.neg   ? -din.yaw.x   : din.yaw.x;
    sy = din.yaw.neg   ? -din.yaw.y   : din.yaw.y;
  end

  // roll times pitch
  always_ff @(posedge clk) begin
    if (en[0]) begin
      cc <= mul(cr, cp);
      sc <= mul(sr, cp);
      cs <= mul(cr, sp);
      ss <= mul(sr, sp);
      cy1 <= cy;
      sy1 <= sy;
    end
  end

  // times yaw
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ccc <= mul(cc, cy1);
      sss <= mul(ss, sy1);
      scc <= mul(sc, cy1);
      css <= mul(cs, sy1);
      csc <= mul(cs, cy1);
      scs <= mul(sc, sy1);
      ccs <= mul(cc, sy1);
      ssc <= mul(ss, cy1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sw  <= ccc + sss;
      sx  <= scc - css;
      sy2 <= csc + scs;
      sz  <= ccs - ssc;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      quat_w <= to_comp(sw);
      quat_x <= to_comp(sx);
      quat_y <= to_comp(sy2);
      quat_z <= to_comp(sz);
    end
  end

endmodule

>>> verif/euler_to_quaternion_checker.sv
`timescale 1ns / 1ps

module euler_to_quaternion_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  output int          fail_count,
  output int          quats_pending
);

  localparam int NumSteps = 16;
  localparam longint PiW = 64'sd3373259426;
  localparam longint HalfPiW = 64'sd1686629713;
  localparam longint TwoPiW = 64'sd6746518852;
  localparam longint GainW = 64'sd652032874;

  longint atan_lut [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 7, 3, 1};

  logic [63:0] quat_queue [$];

  // cosine and sine of half the angle, 30 fraction bits
  function automatic void half_cos_sin(input logic signed [15:0] ang, output longint c,
                                       output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) <<< 17;
    x = GainW;
    y = 0;
    flip = 0;
    if (z > PiW) z -= TwoPiW;
    else if (z < -PiW) z += TwoPiW;
    if (z > HalfPiW) begin
      z -= PiW;
      flip = 1;
    end else if (z < -HalfPiW) begin
      z += PiW;
      flip = 1;
    end
    for (int i = 0; i < NumSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_lut[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_lut[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint fmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic logic [15:0] to_q14(longint v);
    v = (v + (64'sd1 <<< 15)) >>> 16;
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v[15:0];
  endfunction

  function automatic logic [63:0] euler_to_quat(logic [47:0] d);
    longint cr, sr, cp, sp, cy, sy;
    logic [15:0] w, qx, qy, qz;
    half_cos_sin(d[15:0], cr, sr);
    half_cos_sin(d[31:16], cp, sp);
    half_cos_sin(d[47:32], cy, sy);
    w = to_q14(fmul(fmul(cr, cp), cy) + fmul(fmul(sr, sp), sy));
    qx = to_q14(fmul(fmul(sr, cp), cy) - fmul(fmul(cr, sp), sy));
    qy = to_q14(fmul(fmul(cr, sp), cy) + fmul(fmul(sr, cp), sy));
    qz = to_q14(fmul(fmul(cr, cp), sy) - fmul(fmul(sr, sp), cy));
    return {qz, qy, qx, w};
  endfunction

  assign quats_pending = quat_queue.size();

  initial fail_count = 0;

  // predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) quat_queue.push_back(euler_to_quat(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (quat_queue.size() == 0) begin
          $display("%0t: unexpected quaternion %h", $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = quat_queue.pop_front();
          for (int f = 0; f < 4; f++)
            if (want[16*f +: 16] !== m_axis_tdata[16*f +: 16]) begin
              $display("%0t: component %0d expected %h actual %h", $time, f,
                       want[16*f +: 16], m_axis_tdata[16*f +: 16]);
              fail_count++;
            end
        end
      end
    end
  end

endmodule

>>> verif/euler_to_quaternion_tb.sv
`timescale 1ns / 1ps

module euler_to_quaternion_tb;

  localparam int NumRandom = 700;
  localparam int StallLimit = 5000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  int          fail_count;
  int          quats_pending;
  int          idle_cycles;
  bit          hold_off;

  euler_to_quaternion uut (.*);

  euler_to_quaternion_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // offer one triple and wait for its transfer
  task automatic send_angles(input logic [15:0] r, input logic [15:0] p,
                             input logic [15:0] y);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {y, p, r};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_gap();
    int n;
    n = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      n = ($urandom_range(0, 1) == 0) ? gap_len() : 0;
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    logic [15:0] edges [6];
    edges = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h3244};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_off = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes and quadrant fold boundaries, back to back
    for (int i = 0; i < 6; i++) send_angles(edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6]);
    send_angles(16'h3244, 16'h3244, 16'h3244);
    send_angles(16'hcdbc, 16'h1922, 16'he6de);
    send_angles(16'h6488, 16'h9b78, 16'h0000);
    send_angles(16'h0000, 16'h6487, 16'h9b79);
    send_angles(16'h9b78, 16'h0000, 16'h6488);
    send_gap();
    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    for (int i = 0; i < 60; i++)
      send_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
    for (int i = 0; i < NumRandom; i++) begin
      send_angles(pick_angle(), pick_angle(), pick_angle());
      send_gap();
    end
    s_axis_tvalid <= 1'b0;
    while (quats_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
src/e2q_pkg.sv
src/e2q_cell.sv
src/e2q_fold.sv
src/e2q_combine.sv
src/euler_to_quaternion.sv
verif/euler_to_quaternion_checker.sv
verif/euler_to_quaternion_tb.sv
